### rtl/selective_repeat_receiver_macros.svh
// Assertion macros used by the checker file.
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Consequent checked in the same cycle.
`define SRR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srr_checker: property failed");

// Consequent checked in the next cycle.
`define SRR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srr_checker: property failed");

`endif

### rtl/srr_pkg.sv
package srr_pkg;

  localparam int unsigned DefMaxWindow = 32;
  localparam int unsigned DefSeqBits   = 16;

  localparam int unsigned ModW    = 17;
  localparam int unsigned WinW    = 6;
  localparam int unsigned TotW    = 40;
  localparam int unsigned HandleW = 32;
  localparam int unsigned LenW    = 11;
  localparam int unsigned RamWidth = HandleW + LenW;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = TotW;

  localparam logic [ModW-1:0] ModulusRst = 17'd60000;
  localparam logic [WinW-1:0] WindowRst  = 6'd10;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SEQ_MODULUS = 2'd0,
    REG_WINDOW_SIZE = 2'd1,
    REG_TOTAL_BYTES = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_DELIVER = 1'b1
  } kind_e;

endpackage

### rtl/srr_ram.sv
module srr_ram #(
  parameter int unsigned Width = srr_pkg::RamWidth,
  parameter int unsigned Depth = srr_pkg::DefMaxWindow
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/selective_repeat_receiver.sv
// Selective-repeat ARQ receiver. A packet header is taken when start_i is high and busy_o low;
// results leave as one-cycle strobes on result_valid_o with no back-pressure, so the consumer
// must take every result in the cycle it appears. An in-window packet gives an acknowledgement
// followed by one delivery per in-order stored packet, back to back in consecutive cycles;
// last_o marks the final result of the header. The slot RAM has a single read port and is
// walked twice per header: once to total the bytes for the done flag, once to release the
// packets. After the modulus has been lowered to or below the window base, the next data
// header first reduces the base, one bit at a time. Slot valid bits are flops cleared by
// reset, so no clearing pass is needed. cfg_ready_o is always high; write registers only
// while busy_o is low and no results are pending.
module selective_repeat_receiver #(
  parameter int unsigned MAX_WINDOW = srr_pkg::DefMaxWindow,
  parameter int unsigned SEQ_BITS   = srr_pkg::DefSeqBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srr_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [srr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          is_ack_i,
  input  logic [SEQ_BITS-1:0]           seq_num_i,
  input  logic [srr_pkg::HandleW-1:0]   payload_handle_i,
  input  logic [srr_pkg::LenW-1:0]      payload_len_i,
  output logic                          result_valid_o,
  output logic                          kind_o,
  output logic [SEQ_BITS-1:0]           ack_seq_o,
  output logic [SEQ_BITS-1:0]           ack_expected_o,
  output logic [srr_pkg::HandleW-1:0]   deliver_handle_o,
  output logic [srr_pkg::LenW-1:0]      deliver_len_o,
  output logic [srr_pkg::TotW-1:0]      bytes_delivered_o,
  output logic                          done_res_o,
  output logic                          last_o
);

  localparam int unsigned ModW    = srr_pkg::ModW;
  localparam int unsigned WinW    = srr_pkg::WinW;
  localparam int unsigned TotW    = srr_pkg::TotW;
  localparam int unsigned HandleW = srr_pkg::HandleW;
  localparam int unsigned LenW    = srr_pkg::LenW;
  localparam int unsigned RamW    = HandleW + LenW;

  localparam int unsigned SlotW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CntW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned MW      = SEQ_BITS + 1;
  localparam int unsigned ModCmpW = (MW > ModW) ? MW : ModW;
  localparam int unsigned WinCmpW = (CntW > WinW) ? CntW : WinW;
  localparam int unsigned OffCmpW = (MW > CntW) ? MW : CntW;
  localparam int unsigned BitCntW = (SEQ_BITS > 1) ? $clog2(SEQ_BITS) : 1;

  localparam logic [ModCmpW-1:0] ModMax  = ModCmpW'(1) << SEQ_BITS;
  localparam logic [ModCmpW-1:0] ModMin  = ModCmpW'(2);
  localparam logic [WinCmpW-1:0] WinMax  = WinCmpW'(MAX_WINDOW);
  localparam logic [WinCmpW-1:0] WinMin  = WinCmpW'(1);
  localparam logic [CntW-1:0]    CntMax  = CntW'(MAX_WINDOW);
  localparam logic [SlotW-1:0]   SlotTop = SlotW'(MAX_WINDOW - 1);
  localparam logic [SlotW:0]     SlotNum = (SlotW + 1)'(MAX_WINDOW);
  localparam logic [BitCntW-1:0] BitTop  = BitCntW'(SEQ_BITS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_ACK   = 7'b0100000,
    S_DELIV = 7'b1000000
  } state_e;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] p);
    if (p == SlotTop) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [TotW-1:0] sat_add(input logic [TotW-1:0] a,
                                              input logic [LenW-1:0] b);
    logic [TotW:0] s;
    s = {1'b0, a} + (TotW + 1)'(b);
    return s[TotW] ? '1 : s[TotW-1:0];
  endfunction

  // configuration
  logic [ModW-1:0] seq_modulus_q;
  logic [WinW-1:0] window_size_q;
  logic [TotW-1:0] total_q;

  // control state
  state_e                 state_q, state_d;
  logic                   fin_q, fin_d;
  logic [SEQ_BITS-1:0]    base_q, base_d;
  logic [SlotW-1:0]       head_q, head_d;
  logic [TotW-1:0]        count_q, count_d;
  logic [MAX_WINDOW-1:0]  valid_q, valid_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic                   res_valid_q, res_valid_d;

  // datapath
  logic                   in_ack_q;
  logic [SEQ_BITS-1:0]    in_seq_q;
  logic [HandleW-1:0]     in_handle_q;
  logic [LenW-1:0]        in_len_q;
  logic [SlotW-1:0]       ptr_q, ptr_d;
  logic [TotW-1:0]        sum_q, sum_d;
  logic [MW-1:0]          rem_q, rem_d;
  logic [SEQ_BITS-1:0]    sh_q, sh_d;
  logic [BitCntW-1:0]     bit_q, bit_d;

  logic                   kind_q, kind_d;
  logic [SEQ_BITS-1:0]    ack_seq_q, ack_seq_d;
  logic [SEQ_BITS-1:0]    ack_exp_q, ack_exp_d;
  logic [HandleW-1:0]     dhandle_q, dhandle_d;
  logic [LenW-1:0]        dlen_q, dlen_d;
  logic [TotW-1:0]        bytes_q, bytes_d;
  logic                   done_q, done_d;
  logic                   last_q, last_d;

  // slot RAM
  logic                   ram_we, ram_re;
  logic [SlotW-1:0]       ram_raddr;
  logic [RamW-1:0]        ram_rdata;
  logic [HandleW-1:0]     rd_handle;
  logic [LenW-1:0]        rd_len;

  logic                   accept;
  logic [ModCmpW-1:0]     mod_ext, m_wide;
  logic [MW-1:0]          m;
  logic [WinCmpW-1:0]     win_ext, win_wide;
  logic [CntW-1:0]        win;
  logic [MW-1:0]          seq_ext, base_ext, off, below, base_inc, trial;
  logic [OffCmpW-1:0]     off_x, below_x, win_x;
  logic                   seq_ok, in_win, below_hit, issue;
  logic [SlotW:0]         slot_sum;
  logic [SlotW-1:0]       slot_new;
  logic [TotW-1:0]        deliv_count;
  logic                   ack_done;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // effective modulus and window
  assign mod_ext = ModCmpW'(seq_modulus_q);
  assign win_ext = WinCmpW'(window_size_q);

  always_comb begin
    if (mod_ext < ModMin) begin
      m_wide = ModMin;
    end else if (mod_ext > ModMax) begin
      m_wide = ModMax;
    end else begin
      m_wide = mod_ext;
    end
    if (win_ext < WinMin) begin
      win_wide = WinMin;
    end else if (win_ext > WinMax) begin
      win_wide = WinMax;
    end else begin
      win_wide = win_ext;
    end
  end

  assign m   = m_wide[MW-1:0];
  assign win = win_wide[CntW-1:0];

  // window position of the held header
  assign seq_ext  = {1'b0, in_seq_q};
  assign base_ext = {1'b0, base_q};
  assign seq_ok   = (seq_ext < m);

  always_comb begin
    if (seq_ext >= base_ext) begin
      off = seq_ext - base_ext;
    end else begin
      off = seq_ext + (m - base_ext);
    end
    if (base_ext >= seq_ext) begin
      below = base_ext - seq_ext;
    end else begin
      below = base_ext + (m - seq_ext);
    end
  end

  assign off_x     = OffCmpW'(off);
  assign below_x   = OffCmpW'(below);
  assign win_x     = OffCmpW'(win);
  assign in_win    = (off_x < win_x);
  assign below_hit = (below_x != '0) && (below_x <= win_x);

  assign slot_sum = {1'b0, head_q} + {1'b0, off_x[SlotW-1:0]};
  assign slot_new = (slot_sum >= SlotNum) ? SlotW'(slot_sum - SlotNum) : slot_sum[SlotW-1:0];

  assign rd_handle   = ram_rdata[RamW-1:LenW];
  assign rd_len      = ram_rdata[LenW-1:0];
  assign deliv_count = sat_add(count_q, rd_len);
  assign issue       = (cnt_q < CntMax) && valid_q[ptr_q];
  assign ack_done    = (sum_q == total_q);
  assign base_inc    = base_ext + MW'(1);
  assign trial       = {rem_q[MW-2:0], sh_q[SEQ_BITS-1]};

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    base_d      = base_q;
    head_d      = head_q;
    count_d     = count_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    ptr_d       = ptr_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    bit_d       = bit_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;
    res_valid_d = 1'b0;
    kind_d      = srr_pkg::KIND_ACK;
    ack_seq_d   = '0;
    ack_exp_d   = '0;
    dhandle_d   = '0;
    dlen_d      = '0;
    bytes_d     = count_q;
    done_d      = fin_q;
    last_d      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (fin_q) begin
          state_d = S_IDLE;
        end else if (in_ack_q) begin
          fin_d   = (count_q == total_q);
          state_d = S_IDLE;
        end else if (!seq_ok) begin
          state_d = S_IDLE;
        end else if (base_ext >= m) begin
          // modulus was lowered: reduce the base, one bit a cycle
          rem_d   = '0;
          sh_d    = base_q;
          bit_d   = BitTop;
          state_d = S_MOD;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_MOD: begin
        rem_d = (trial >= m) ? trial - m : trial;
        sh_d  = sh_q << 1;
        if (bit_q == '0) begin
          base_d  = rem_d[SEQ_BITS-1:0];
          state_d = S_EVAL;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end
      S_EVAL: begin
        ptr_d  = head_q;
        cnt_d  = '0;
        pend_d = 1'b0;
        sum_d  = count_q;
        if (in_win) begin
          ram_we            = 1'b1;
          valid_d[slot_new] = 1'b1;
          state_d           = S_SCAN;
        end else if (below_hit) begin
          state_d = S_ACK;
        end else begin
          fin_d   = (count_q == total_q);
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // first walk: total the bytes so every result can carry the done flag
        if (pend_q) begin
          sum_d = sat_add(sum_q, rd_len);
        end
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q;
          ptr_d     = slot_inc(ptr_q);
          cnt_d     = cnt_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_ACK;
        end
      end
      S_ACK: begin
        res_valid_d = 1'b1;
        kind_d      = srr_pkg::KIND_ACK;
        ack_seq_d   = in_seq_q;
        ack_exp_d   = base_q;
        bytes_d     = count_q;
        done_d      = ack_done;
        fin_d       = ack_done;
        last_d      = (cnt_q == '0);
        if (cnt_q == '0) begin
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_q;
          state_d   = S_DELIV;
        end
      end
      S_DELIV: begin
        res_valid_d     = 1'b1;
        kind_d          = srr_pkg::KIND_DELIVER;
        dhandle_d       = rd_handle;
        dlen_d          = rd_len;
        bytes_d         = deliv_count;
        done_d          = fin_q;
        last_d          = (cnt_q == CntW'(1));
        count_d         = deliv_count;
        valid_d[head_q] = 1'b0;
        head_d          = slot_inc(head_q);
        base_d          = (base_inc == m) ? '0 : base_inc[SEQ_BITS-1:0];
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_inc(head_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_modulus_q <= srr_pkg::ModulusRst;
      window_size_q <= srr_pkg::WindowRst;
      total_q       <= '0;
      state_q       <= S_IDLE;
      fin_q         <= 1'b0;
      base_q        <= '0;
      head_q        <= '0;
      count_q       <= '0;
      valid_q       <= '0;
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          srr_pkg::REG_SEQ_MODULUS: seq_modulus_q <= cfg_wdata_i[ModW-1:0];
          srr_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_wdata_i[WinW-1:0];
          srr_pkg::REG_TOTAL_BYTES: total_q       <= cfg_wdata_i[TotW-1:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      fin_q       <= fin_d;
      base_q      <= base_d;
      head_q      <= head_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_ack_q    <= is_ack_i;
      in_seq_q    <= seq_num_i;
      in_handle_q <= payload_handle_i;
      in_len_q    <= payload_len_i;
    end
    ptr_q     <= ptr_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    sh_q      <= sh_d;
    bit_q     <= bit_d;
    kind_q    <= kind_d;
    ack_seq_q <= ack_seq_d;
    ack_exp_q <= ack_exp_d;
    dhandle_q <= dhandle_d;
    dlen_q    <= dlen_d;
    bytes_q   <= bytes_d;
    done_q    <= done_d;
    last_q    <= last_d;
  end

  srr_ram #(
    .Width (RamW),
    .Depth (MAX_WINDOW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_new),
    .wdata_i ({in_handle_q, in_len_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign result_valid_o    = res_valid_q;
  assign kind_o            = kind_q;
  assign ack_seq_o         = ack_seq_q;
  assign ack_expected_o    = ack_exp_q;
  assign deliver_handle_o  = dhandle_q;
  assign deliver_len_o     = dlen_q;
  assign bytes_delivered_o = bytes_q;
  assign done_res_o        = done_q;
  assign last_o            = last_q;

endmodule

### rtl/srr_checker.sv
`include "selective_repeat_receiver_macros.svh"

module srr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     result_valid_o,
  input logic                     kind_o,
  input logic [srr_pkg::TotW-1:0] bytes_delivered_o,
  input logic                     done_res_o,
  input logic                     last_o
);

  // a taken header keeps the block busy for at least the next cycle
  `SRR_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)

  // more results of the same header still to come
  `SRR_ASSERT_SAME(a_burst_busy, result_valid_o && !last_o, busy_o)

  // results of one header come back to back, deliveries after the acknowledgement
  `SRR_ASSERT_NEXT(a_burst_contig, result_valid_o && !last_o,
                   result_valid_o && kind_o == srr_pkg::KIND_DELIVER)

  `SRR_ASSERT_NEXT(a_done_steady, result_valid_o && !last_o,
                   done_res_o == $past(done_res_o))

  `SRR_ASSERT_NEXT(a_count_grows, result_valid_o && !last_o,
                   bytes_delivered_o >= $past(bytes_delivered_o))

endmodule

bind selective_repeat_receiver srr_checker u_srr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .result_valid_o    (result_valid_o),
  .kind_o            (kind_o),
  .bytes_delivered_o (bytes_delivered_o),
  .done_res_o        (done_res_o),
  .last_o            (last_o)
);
